@@ hdl/pmtu_pkg.sv @@
// Shared types and codes for the path-MTU cache table.
package pmtu_pkg;

  localparam int unsigned KeyW   = 48;
  localparam int unsigned SizeW  = 16;
  localparam int unsigned CoolW  = 32;
  localparam int unsigned BholeW = 8;
  localparam int unsigned CountW = 5;

  typedef enum logic [2:0] {
    CMD_FIND      = 3'd0,
    CMD_SUCCESS   = 3'd1,
    CMD_BLACKHOLE = 3'd2,
    CMD_FAILURE   = 3'd3,
    CMD_CLEARCD   = 3'd4,
    CMD_ERASE     = 3'd5,
    CMD_CLEARALL  = 3'd6,
    CMD_SIZE      = 3'd7
  } pmtu_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } pmtu_state_e;

  typedef struct packed {
    pmtu_cmd_e           command;
    logic [KeyW-1:0]     peer_key;
    logic [SizeW-1:0]    payload_size;
    logic [CoolW-1:0]    cooldown_until;
    logic [BholeW-1:0]   blackhole_count;
  } pmtu_in_t;

  typedef struct packed {
    logic                found;
    logic [SizeW-1:0]    entry_size;
    logic [CoolW-1:0]    entry_cooldown;
    logic [BholeW-1:0]   entry_blackholes;
    logic [CountW-1:0]   entry_count;
    logic                table_full;
  } pmtu_out_t;

  // Data part of one table slot, kept in the entry memory.
  typedef struct packed {
    logic [SizeW-1:0]    size;
    logic [CoolW-1:0]    cooldown;
    logic [BholeW-1:0]   blackholes;
  } pmtu_entry_t;

  // Key store write controls.
  typedef struct packed {
    logic set;
    logic clear;
    logic clear_all;
  } pmtu_key_wr_t;

  // Decision of the merge stage for one item.
  typedef struct packed {
    logic        write;
    logic        set_valid;
    logic        clr_valid;
    logic        clr_all;
    logic        found;
    logic        full;
    pmtu_entry_t entry;
  } pmtu_act_t;

endpackage

@@ hdl/pmtu_key_match.sv @@
// Key store with valid bits, parallel key compare and lowest free slot search.
module pmtu_key_match #(
  parameter int unsigned ENTRIES = 16,
  localparam int unsigned IdxW   = $clog2(ENTRIES)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [pmtu_pkg::KeyW-1:0]  lookup_key_i,
  input  pmtu_pkg::pmtu_key_wr_t     wr_i,
  input  logic [IdxW-1:0]            wr_idx_i,
  output logic                       hit_o,
  output logic [IdxW-1:0]            hit_idx_o,
  output logic                       free_ok_o,
  output logic [IdxW-1:0]            free_idx_o
);

  logic [ENTRIES-1:0]               valid_q;
  logic [pmtu_pkg::KeyW-1:0]        key_q [ENTRIES];
  logic [ENTRIES-1:0]               match_vec;
  logic [ENTRIES-1:0]               free_vec;
  logic [ENTRIES-1:0]               match_oh;
  logic [ENTRIES-1:0]               free_oh;

  // Compare every valid slot against the key
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = valid_q[i] && (key_q[i] == lookup_key_i);
    end
    free_vec = ~valid_q;
  end

  // Isolate the lowest set bit of each vector
  assign match_oh = match_vec & (~match_vec + ENTRIES'(1));
  assign free_oh  = free_vec & (~free_vec + ENTRIES'(1));

  // Encode the one-hot picks into slot numbers
  always_comb begin
    hit_idx_o  = '0;
    free_idx_o = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_oh[i]) hit_idx_o  = hit_idx_o | IdxW'(i);
      if (free_oh[i])  free_idx_o = free_idx_o | IdxW'(i);
    end
  end

  assign hit_o     = |match_vec;
  assign free_ok_o = |free_vec;

  // Update valid bits; clear all wins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.clear_all) begin
      valid_q <= '0;
    end else if (wr_i.set) begin
      valid_q[wr_idx_i] <= 1'b1;
    end else if (wr_i.clear) begin
      valid_q[wr_idx_i] <= 1'b0;
    end
  end

  // Store the key of a newly inserted slot
  always_ff @(posedge clk_i) begin
    if (wr_i.set) begin
      key_q[wr_idx_i] <= lookup_key_i;
    end
  end

endmodule

@@ hdl/pmtu_entry_ram.sv @@
// Slot data memory: one write port, one registered read port.
module pmtu_entry_ram #(
  parameter int unsigned ENTRIES = 16,
  localparam int unsigned IdxW   = $clog2(ENTRIES)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [IdxW-1:0]       waddr_i,
  input  pmtu_pkg::pmtu_entry_t wdata_i,
  input  logic                  re_i,
  input  logic [IdxW-1:0]       raddr_i,
  output pmtu_pkg::pmtu_entry_t rdata_o
);

  pmtu_pkg::pmtu_entry_t mem [ENTRIES];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ hdl/pmtu_merge.sv @@
// Command decode and field merge of one item against the looked-up slot.
module pmtu_merge (
  input  pmtu_pkg::pmtu_in_t    item_i,
  input  logic                  hit_i,
  input  logic                  free_ok_i,
  input  pmtu_pkg::pmtu_entry_t rdata_i,
  output pmtu_pkg::pmtu_act_t   act_o
);

  pmtu_pkg::pmtu_entry_t base;
  pmtu_pkg::pmtu_entry_t merged;

  // A miss starts from an empty slot
  assign base = hit_i ? rdata_i : '0;

  // Merge the update fields into the slot
  always_comb begin
    merged = base;
    unique case (item_i.command) inside
      pmtu_pkg::CMD_SUCCESS: begin
        if (item_i.payload_size > base.size) merged.size = item_i.payload_size;
        merged.cooldown   = '0;
        merged.blackholes = '0;
      end
      pmtu_pkg::CMD_BLACKHOLE, pmtu_pkg::CMD_FAILURE: begin
        if (item_i.command == pmtu_pkg::CMD_FAILURE || item_i.payload_size > base.size) begin
          merged.size = item_i.payload_size;
        end
        if (item_i.cooldown_until > base.cooldown) merged.cooldown = item_i.cooldown_until;
        if (item_i.blackhole_count > base.blackholes) begin
          merged.blackholes = item_i.blackhole_count;
        end
      end
      default: begin
        merged.cooldown   = '0;
        merged.blackholes = '0;
      end
    endcase
  end

  // Decide writes, valid changes and the reported slot
  always_comb begin
    act_o       = '0;
    act_o.found = hit_i;
    unique case (item_i.command) inside
      pmtu_pkg::CMD_SUCCESS, pmtu_pkg::CMD_BLACKHOLE, pmtu_pkg::CMD_FAILURE: begin
        if (item_i.command != pmtu_pkg::CMD_BLACKHOLE && item_i.payload_size == '0) begin
          act_o.entry = base;
        end else if (!hit_i && !free_ok_i) begin
          act_o.full = 1'b1;
        end else begin
          act_o.write     = 1'b1;
          act_o.set_valid = !hit_i;
          act_o.entry     = merged;
        end
      end
      pmtu_pkg::CMD_CLEARCD: begin
        if (hit_i) begin
          act_o.write = 1'b1;
          act_o.entry = merged;
        end
      end
      pmtu_pkg::CMD_ERASE: begin
        act_o.clr_valid = hit_i;
      end
      pmtu_pkg::CMD_CLEARALL: begin
        act_o.clr_all = 1'b1;
      end
      default: begin
        act_o.entry = base;
      end
    endcase
  end

endmodule

@@ hdl/path_mtu_cache_table_unit.sv @@
// Top level of the path-MTU cache table.
//
//  channel   ports                      handshake
//  --------  -------------------------  ------------------------------------
//  command   start, busy, item_i        taken at an edge with start && !busy
//  result    done_o, result_o           done_o high one cycle, never stalled
//
// An item passes through a key compare cycle that also reads the slot
// memory, then a merge cycle that writes it back. The result shows in the
// cycle after the merge; busy is low during the merge cycle, so the next
// item can be taken while the current one merges. The single memory read
// port and the read-then-write of the slot keep busy high in the compare
// cycle. Reset clears the valid bits and the count at once; there is no
// clearing pass. The receiver cannot stall, so results never wait.
module path_mtu_cache_table_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  pmtu_pkg::pmtu_in_t  item_i,
  output logic               done_o,
  output pmtu_pkg::pmtu_out_t result_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  pmtu_pkg::pmtu_state_e  state_q, state_d;
  pmtu_pkg::pmtu_in_t     item_q;
  pmtu_pkg::pmtu_entry_t  rdata;
  pmtu_pkg::pmtu_act_t    act;
  pmtu_pkg::pmtu_key_wr_t key_wr;
  pmtu_pkg::pmtu_out_t    result_q;
  logic [CntW-1:0]        count_q, count_d;
  logic                   done_q;
  logic                   accept;
  logic                   rd_en;
  logic                   upd_en;
  logic                   hit, free_ok;
  logic [IdxW-1:0]        hit_idx, free_idx;
  logic                   hit_q, free_ok_q;
  logic [IdxW-1:0]        hit_idx_q, free_idx_q;
  logic [IdxW-1:0]        dest_idx;

  assign accept = start && !busy;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pmtu_pkg::ST_IDLE:   if (accept) state_d = pmtu_pkg::ST_LOOKUP;
      pmtu_pkg::ST_LOOKUP: state_d = pmtu_pkg::ST_UPDATE;
      pmtu_pkg::ST_UPDATE: state_d = accept ? pmtu_pkg::ST_LOOKUP : pmtu_pkg::ST_IDLE;
      default:             state_d = pmtu_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    busy   = 1'b0;
    rd_en  = 1'b0;
    upd_en = 1'b0;
    unique case (state_q)
      pmtu_pkg::ST_LOOKUP: begin
        busy  = 1'b1;
        rd_en = 1'b1;
      end
      pmtu_pkg::ST_UPDATE: upd_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pmtu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the accepted item and the lookup outcome
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= item_i;
    if (rd_en) begin
      hit_q      <= hit;
      hit_idx_q  <= hit_idx;
      free_ok_q  <= free_ok;
      free_idx_q <= free_idx;
    end
  end

  assign dest_idx = hit_q ? hit_idx_q : free_idx_q;

  // Key store writes happen only in the merge cycle
  always_comb begin
    key_wr.set       = upd_en && act.set_valid;
    key_wr.clear     = upd_en && act.clr_valid;
    key_wr.clear_all = upd_en && act.clr_all;
  end

  pmtu_key_match #(
    .ENTRIES(ENTRIES)
  ) u_key_match (
    .clk_i,
    .rst_ni,
    .lookup_key_i (item_q.peer_key),
    .wr_i         (key_wr),
    .wr_idx_i     (dest_idx),
    .hit_o        (hit),
    .hit_idx_o    (hit_idx),
    .free_ok_o    (free_ok),
    .free_idx_o   (free_idx)
  );

  pmtu_entry_ram #(
    .ENTRIES(ENTRIES)
  ) u_entry_ram (
    .clk_i,
    .we_i    (upd_en && act.write),
    .waddr_i (dest_idx),
    .wdata_i (act.entry),
    .re_i    (rd_en),
    .raddr_i (hit_idx),
    .rdata_o (rdata)
  );

  pmtu_merge u_merge (
    .item_i    (item_q),
    .hit_i     (hit_q),
    .free_ok_i (free_ok_q),
    .rdata_i   (rdata),
    .act_o     (act)
  );

  // Track the number of valid slots
  always_comb begin
    count_d = count_q;
    if (upd_en) begin
      if (act.clr_all)        count_d = '0;
      else if (act.set_valid) count_d = count_q + CntW'(1);
      else if (act.clr_valid) count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= upd_en;
    end
  end

  // Register the result of the merge cycle
  always_ff @(posedge clk_i) begin
    if (upd_en) begin
      result_q.found            <= act.found;
      result_q.entry_size       <= act.entry.size;
      result_q.entry_cooldown   <= act.entry.cooldown;
      result_q.entry_blackholes <= act.entry.blackholes;
      result_q.entry_count      <= pmtu_pkg::CountW'(count_d);
      result_q.table_full       <= act.full;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // A result follows exactly one merge cycle
  a_done_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == pmtu_pkg::ST_UPDATE))
    else $error("result strobe without a merge cycle");

  // The count never exceeds the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ENTRIES))
    else $error("valid count beyond table size");

  // A dropped insert reports a miss with empty fields
  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.table_full) |->
      (!result_o.found && result_o.entry_size == '0 &&
       result_o.entry_cooldown == '0 && result_o.entry_blackholes == '0))
    else $error("dropped insert reports slot data");

  // An accepted item always goes through the compare cycle
  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == pmtu_pkg::ST_LOOKUP && busy))
    else $error("accepted item skipped the compare cycle");

  // Insert only when a slot is free
  a_insert_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_en && act.set_valid) |-> (free_ok_q && !hit_q && count_q < CntW'(ENTRIES)))
    else $error("insert into a full table");

endmodule
